@@ rtl/dpct_pkg.sv @@
// ----------------------------------------------------------------------------
// dpct_pkg: shared types for the disk pair collision time block
// Word layouts of the input and result channels and the fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package dpct_pkg;

    localparam int CW = 32;  // coordinate width
    localparam int FW = 16;  // fraction bits

    typedef struct packed {
        logic signed [CW-1:0] a_pos_x;
        logic signed [CW-1:0] a_pos_y;
        logic signed [CW-1:0] a_vel_x;
        logic signed [CW-1:0] a_vel_y;
        logic        [CW-2:0] a_rad;
        logic signed [CW-1:0] b_pos_x;
        logic signed [CW-1:0] b_pos_y;
        logic signed [CW-1:0] b_vel_x;
        logic signed [CW-1:0] b_vel_y;
        logic        [CW-2:0] b_rad;
    } t_in;

    typedef struct packed {
        logic          hits;
        logic [CW-1:0] hit_time;
        logic          time_saturated;
    } t_out;

endpackage

`default_nettype wire

@@ rtl/disk_pair_collision_time.sv @@
// ----------------------------------------------------------------------------
// disk_pair_collision_time: contact time of two moving disks
// Fixed-point pipeline: products, discriminant, square root, division.
// ----------------------------------------------------------------------------
// Usage: the input channel (i_in_valid, o_in_ready, i_in_data) takes one word
// holding position, velocity and radius of two disks. The output channel
// (o_out_valid, i_out_ready, o_out_data) returns one word per input word, in
// order: a hit flag, the contact time in unsigned Q16.16 and a flag that is
// set when that time was clamped (too large, or the disks already overlap).
// Throughput is one word per cycle while the receiver does not stall. The
// result passes, after the difference stage, through two multiplier levels
// of three stages each, a discriminant stage, 17 square root stages at four
// bits each, a numerator stage, 8 divider stages at four quotient bits each
// and the output register. Each pipeline stage carries its valid bit.
// When the receiver stalls with the output register full, the whole pipeline
// holds, so no word is lost; the output register sits behind the pipeline and
// a new word is accepted whenever the output register is empty or being taken.
// Reset clears all valid bits; the data registers are not reset.
`default_nettype none

module disk_pair_collision_time
    import dpct_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output      logic o_in_ready,
    input  wire t_in  i_in_data,
    output      logic o_out_valid,
    input  wire logic i_out_ready,
    output      t_out o_out_data
);
    localparam int DVW = CW + 1;          // difference width
    localparam int P1  = 2 * DVW;         // product width
    localparam int S1  = P1 + 1;          // sum of two products
    localparam int DQ  = 2 * S1 + 2;      // disc width (signed)
    localparam int SQW = 2 * S1 + 2;      // sqrt input width (even)
    localparam int RTW = SQW / 2;
    localparam int NMW = RTW + 2 + FW;    // numerator width
    localparam int SQS = (RTW + 3) / 4;
    localparam int DVS = (CW + 3) / 4;
    localparam int LAT = 1 + 3 + 3 + 1 + SQS + 1 + DVS;

    logic en;
    logic [LAT-1:0] r_v;

    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    // Stage 1: differences and radius sum.
    logic signed [DVW-1:0] r_dx, r_dy, r_vx, r_vy;
    logic        [CW-1:0]  r_sg;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dx <= DVW'(i_in_data.b_pos_x) - DVW'(i_in_data.a_pos_x);
            r_dy <= DVW'(i_in_data.b_pos_y) - DVW'(i_in_data.a_pos_y);
            r_vx <= DVW'(i_in_data.b_vel_x) - DVW'(i_in_data.a_vel_x);
            r_vy <= DVW'(i_in_data.b_vel_y) - DVW'(i_in_data.a_vel_y);
            r_sg <= CW'(i_in_data.a_rad) + CW'(i_in_data.b_rad);
        end
    end

    // Level A: seven products.
    logic signed [P1-1:0] p_dxvx, p_dyvy, p_vxvx, p_vyvy, p_dxdx, p_dydy, p_ss;
    dpct_mul #(.AW(DVW), .BW(DVW)) u_m0 (.i_clk, .i_en(en), .i_a(r_dx), .i_b(r_vx), .o_p(p_dxvx));
    dpct_mul #(.AW(DVW), .BW(DVW)) u_m1 (.i_clk, .i_en(en), .i_a(r_dy), .i_b(r_vy), .o_p(p_dyvy));
    dpct_mul #(.AW(DVW), .BW(DVW)) u_m2 (.i_clk, .i_en(en), .i_a(r_vx), .i_b(r_vx), .o_p(p_vxvx));
    dpct_mul #(.AW(DVW), .BW(DVW)) u_m3 (.i_clk, .i_en(en), .i_a(r_vy), .i_b(r_vy), .o_p(p_vyvy));
    dpct_mul #(.AW(DVW), .BW(DVW)) u_m4 (.i_clk, .i_en(en), .i_a(r_dx), .i_b(r_dx), .o_p(p_dxdx));
    dpct_mul #(.AW(DVW), .BW(DVW)) u_m5 (.i_clk, .i_en(en), .i_a(r_dy), .i_b(r_dy), .o_p(p_dydy));
    dpct_mul #(.AW(DVW), .BW(DVW)) u_m6 (.i_clk, .i_en(en),
        .i_a($signed({1'b0, r_sg})), .i_b($signed({1'b0, r_sg})), .o_p(p_ss));

    // Level B: dot products and c = drdr - sigma^2.
    logic signed [S1-1:0] dvdr, dvdv, cc;
    assign dvdr = S1'(p_dxvx) + S1'(p_dyvy);
    assign dvdv = S1'(p_vxvx) + S1'(p_vyvy);
    assign cc   = S1'(S1'(p_dxdx) + S1'(p_dydy)) - S1'(p_ss);

    // Level C: dvdr^2 and dvdv*c, with dvdr and dvdv carried alongside.
    logic signed [2*S1-1:0] q_bb, q_ac;
    dpct_mul #(.AW(S1), .BW(S1)) u_m7 (.i_clk, .i_en(en), .i_a(dvdr), .i_b(dvdr), .o_p(q_bb));
    dpct_mul #(.AW(S1), .BW(S1)) u_m8 (.i_clk, .i_en(en), .i_a(dvdv), .i_b(cc), .o_p(q_ac));
    logic signed [S1-1:0] r_b1, r_b2, r_b3, r_a1, r_a2, r_a3;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b1 <= dvdr; r_b2 <= r_b1; r_b3 <= r_b2;
            r_a1 <= dvdv; r_a2 <= r_a1; r_a3 <= r_a2;
        end
    end

    // Discriminant register stage.
    logic signed [DQ-1:0] r_disc;
    logic signed [S1-1:0] r_b4, r_a4;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_disc <= DQ'(q_bb) - DQ'(q_ac);
            r_b4   <= r_b3;
            r_a4   <= r_a3;
        end
    end

    // Square root; dvdr and dvdv ride a delay line of the same length.
    logic [RTW-1:0] root;
    dpct_sqrt #(.NW(SQW), .SB(4)) u_sq (
        .i_clk, .i_en(en),
        .i_n(r_disc[DQ-1] ? '0 : SQW'(r_disc)), .o_root(root));
    logic signed [S1-1:0] r_bd [SQS];
    logic signed [S1-1:0] r_ad [SQS];
    logic                 r_nd [SQS];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_bd[0] <= r_b4;
            r_ad[0] <= r_a4;
            r_nd[0] <= !r_b4[S1-1] || r_disc[DQ-1] || (r_a4 == '0);
            for (int i = 1; i < SQS; i++) begin
                r_bd[i] <= r_bd[i-1];
                r_ad[i] <= r_ad[i-1];
                r_nd[i] <= r_nd[i-1];
            end
        end
    end

    // Numerator stage.
    logic signed [NMW-1:0] r_num;
    logic [S1-1:0]         r_den;
    logic                  r_none, r_ngt;
    logic signed [NMW-1:0] num;
    assign num = NMW'(-r_bd[SQS-1]) - NMW'($signed({1'b0, root}));
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_num  <= num;
            r_den  <= r_ad[SQS-1];
            r_none <= r_nd[SQS-1];
            r_ngt  <= num[NMW-1];
        end
    end

    logic [CW-1:0] quo;
    logic          big;
    dpct_div #(.NW(NMW + FW), .DW(S1), .QW(CW), .SB(4)) u_dv (
        .i_clk, .i_en(en),
        .i_num(r_ngt ? '0 : (NMW + FW)'(r_num) << FW),
        .i_den(r_den), .o_q(quo), .o_big(big));
    logic r_fn [DVS];
    logic r_fg [DVS];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fn[0] <= r_none;
            r_fg[0] <= r_ngt;
            for (int i = 1; i < DVS; i++) begin
                r_fn[i] <= r_fn[i-1];
                r_fg[i] <= r_fg[i-1];
            end
        end
    end

    // Valid bits march with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[LAT-2:0], i_in_valid};
        end
    end

    // Result register.
    t_out n_out;
    always_comb begin
        n_out = '0;
        if (r_fn[DVS-1]) begin
            n_out = '0;
        end else if (r_fg[DVS-1]) begin
            n_out.hits = 1'b1;
            n_out.time_saturated = 1'b1;
        end else if (big) begin
            n_out.hits = 1'b1;
            n_out.hit_time = '1;
            n_out.time_saturated = 1'b1;
        end else begin
            n_out.hits = 1'b1;
            n_out.hit_time = quo;
        end
    end

    logic r_ov;
    t_out r_out;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_v[LAT-1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("result changed during stall");
    a_nohit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.hits |-> o_out_data.hit_time == '0
        && !o_out_data.time_saturated)
        else $error("no-hit result carries data");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken while output stalled");
`endif
endmodule

`default_nettype wire

@@ rtl/dpct_mul.sv @@
// ----------------------------------------------------------------------------
// dpct_mul: pipelined signed multiplier
// Wide signed product split into 32-bit partial products over three stages.
// ----------------------------------------------------------------------------
`default_nettype none

module dpct_mul #(
    parameter int AW = 66,
    parameter int BW = 66
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_en,
    input  wire logic signed [AW-1:0]    i_a,
    input  wire logic signed [BW-1:0]    i_b,
    output      logic signed [AW+BW-1:0] o_p
);
    localparam int PW = AW + BW;
    localparam int HB = 32;
    localparam int NA = (AW + HB - 1) / HB;
    localparam int NB = (BW + HB - 1) / HB;
    logic [AW-1:0]        a_mag;
    logic [BW-1:0]        b_mag;
    logic                 sgn;
    logic [AW-1:0]        r_a;
    logic [BW-1:0]        r_b;
    logic                 r_s0;
    logic [63:0]          r_pp [NA*NB];
    logic                 r_s1;
    logic [PW-1:0]        n_p;
    logic signed [PW-1:0] r_p;

    assign a_mag = i_a[AW-1] ? AW'(-i_a) : AW'(i_a);
    assign b_mag = i_b[BW-1] ? BW'(-i_b) : BW'(i_b);
    assign sgn   = i_a[AW-1] ^ i_b[BW-1];

    // The partial products, each registered on its own, are summed by shifting.
    always_comb begin
        n_p = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                n_p = n_p + (PW'(r_pp[i * NB + j]) << (i * HB + j * HB));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a  <= a_mag;
            r_b  <= b_mag;
            r_s0 <= sgn;
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    r_pp[i * NB + j] <= 64'(32'(r_a >> (i * HB)))
                                      * 64'(32'(r_b >> (j * HB)));
                end
            end
            r_s1 <= r_s0;
            r_p  <= r_s1 ? -$signed(n_p) : $signed(n_p);
        end
    end

    assign o_p = r_p;
endmodule

`default_nettype wire

@@ rtl/dpct_sqrt.sv @@
// ----------------------------------------------------------------------------
// dpct_sqrt: pipelined integer square root
// SB result bits per stage, restoring method.
// ----------------------------------------------------------------------------
`default_nettype none

module dpct_sqrt #(
    parameter int NW = 132,
    parameter int SB = 4
) (
    input  wire logic            i_clk,
    input  wire logic            i_en,
    input  wire logic [NW-1:0]   i_n,
    output      logic [NW/2-1:0] o_root
);
    localparam int RW = NW / 2;
    localparam int ST = (RW + SB - 1) / SB;
    logic [NW-1:0] r_rem [ST+1];
    logic [RW-1:0] r_q   [ST+1];

    assign r_rem[0] = i_n;
    assign r_q[0]   = '0;

    for (genvar s = 0; s < ST; s++) begin : g_st
        logic [NW-1:0] n_rem;
        logic [RW-1:0] n_q;
        logic [NW+1:0] t;
        always_comb begin
            n_rem = r_rem[s];
            n_q   = r_q[s];
            t     = '0;
            for (int k = 0; k < SB; k++) begin
                if (s * SB + k < RW) begin
                    // Trial term 2*q*2^pos + 2^(2*pos), with q held at its final weight.
                    t = ((NW+2)'(n_q) << (RW - s * SB - k))
                      | ((NW+2)'(1) << (2 * (RW - 1 - s * SB - k)));
                    if ((NW+2)'(n_rem) >= t) begin
                        n_rem = NW'((NW+2)'(n_rem) - t);
                        n_q   = n_q | (RW'(1) << (RW - 1 - s * SB - k));
                    end
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= n_rem;
                r_q[s+1]   <= n_q;
            end
        end
    end

    assign o_root = r_q[ST];
endmodule

`default_nettype wire

@@ rtl/dpct_div.sv @@
// ----------------------------------------------------------------------------
// dpct_div: pipelined restoring divider
// Quotient bits produced a few per stage; flags a quotient above the output range.
// ----------------------------------------------------------------------------
`default_nettype none

module dpct_div #(
    parameter int NW = 84,
    parameter int DW = 66,
    parameter int QW = 32,
    parameter int SB = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output      logic [QW-1:0] o_q,
    output      logic          o_big
);
    localparam int ST = (QW + SB - 1) / SB;
    localparam int RW = DW + 1;
    logic [NW-1:0] r_n   [ST+1];
    logic [DW-1:0] r_d   [ST+1];
    logic [RW-1:0] r_rem [ST+1];
    logic [QW-1:0] r_q   [ST+1];
    logic          r_big [ST+1];
    logic [NW:0]   dsh;

    // Quotient fits in QW bits only if num < den * 2^QW.
    assign dsh      = (NW+1)'(i_den) << QW;
    assign r_big[0] = (NW+1)'(i_num) >= dsh;
    assign r_n[0]   = i_num;
    assign r_d[0]   = i_den;
    assign r_rem[0] = RW'(i_num >> QW);
    assign r_q[0]   = '0;

    for (genvar s = 0; s < ST; s++) begin : g_st
        logic [RW-1:0] n_rem;
        logic [QW-1:0] n_q;
        always_comb begin
            n_rem = r_rem[s];
            n_q   = r_q[s];
            for (int k = 0; k < SB; k++) begin
                if (s * SB + k < QW) begin
                    n_rem = {n_rem[RW-2:0], r_n[s][QW - 1 - s * SB - k]};
                    if (n_rem >= RW'(r_d[s])) begin
                        n_rem = n_rem - RW'(r_d[s]);
                        n_q   = n_q | (QW'(1) << (QW - 1 - s * SB - k));
                    end
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[s+1]   <= r_n[s];
                r_d[s+1]   <= r_d[s];
                r_rem[s+1] <= n_rem;
                r_q[s+1]   <= n_q;
                r_big[s+1] <= r_big[s];
            end
        end
    end

    assign o_q   = r_q[ST];
    assign o_big = r_big[ST];
endmodule

`default_nettype wire
